### hdl/sof_pkg.sv
// Shared types, codes and helper functions for the segmented operand fetch core.
// No dependencies; imported by sof_addr_mod, the top level and both testbench files.
`default_nettype none

package sof_pkg;

    localparam int REG_COUNT  = 16;
    localparam int REG_AW     = 4;
    localparam int SOF_ADDR_W = 17;     // checked byte address before the RAM wrap

    typedef enum logic [1:0] {
        ACT_FETCH = 2'd0,
        ACT_WREG  = 2'd1,
        ACT_WSEG  = 2'd2,
        ACT_WMEM  = 2'd3
    } sof_action_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_REG  = 2'd1,
        KIND_IMM  = 2'd2,
        KIND_MEM  = 2'd3
    } sof_kind_t;

    typedef enum logic [1:0] {
        RMOD_FULL  = 2'd0,
        RMOD_LOW8  = 2'd1,
        RMOD_HIGH8 = 2'd2,
        RMOD_LOW16 = 2'd3
    } sof_rmod_t;

    localparam logic [1:0] SMOD_HALF = 2'd2;
    localparam logic [1:0] SMOD_BYTE = 2'd3;

    function automatic logic [31:0] sext8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [2:0] cells_of(input logic [1:0] smod);
        logic [2:0] n;
        case (smod)
            SMOD_BYTE: n = 3'd1;
            SMOD_HALF: n = 3'd2;
            default:   n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [31:0] reg_operand(input logic [31:0] r, input logic [1:0] rmod);
        logic [31:0] v;
        case (sof_rmod_t'(rmod))
            RMOD_FULL:  v = r;
            RMOD_LOW8:  v = sext8(r[7:0]);
            RMOD_HIGH8: v = sext8(r[15:8]);
            RMOD_LOW16: v = sext16(r[15:0]);
            default:    v = r;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hdl/sof_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module sof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/sof_addr_mod.sv
// Address wrap unit: reduces a checked byte address modulo the RAM size.
// Depends on sof_pkg; reciprocal multiply, back-multiply and one correcting subtract,
// each registered in turn; done pulses as the remainder register is loaded.
`default_nettype none

module sof_addr_mod
    import sof_pkg::*;
#(
    parameter int MEM_BYTES = 16384,
    parameter int AW        = $clog2(MEM_BYTES)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [SOF_ADDR_W-1:0] addr_in,
    output logic                       done,
    output logic      [AW-1:0]         rem
);

    // quotient estimate is exact or one low, so one subtract corrects it
    localparam int RECIP = (1 << SOF_ADDR_W) / MEM_BYTES;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PW    = SOF_ADDR_W + RW;

    logic [SOF_ADDR_W-1:0] addr_reg;
    logic [RW-1:0]         quot_reg, quot_next;
    logic [SOF_ADDR_W-1:0] diff_reg, diff_next;
    logic [AW-1:0]         rem_reg, rem_next;
    logic [PW-1:0]         scaled;
    logic [PW-1:0]         back;
    logic [3:0]            stage_reg;

    always_comb begin
        scaled    = PW'(addr_reg) * PW'(RECIP);
        quot_next = scaled[PW-1:SOF_ADDR_W];
        back      = PW'(quot_reg) * PW'(MEM_BYTES);
        diff_next = addr_reg - back[SOF_ADDR_W-1:0];
        rem_next  = (diff_reg >= SOF_ADDR_W'(MEM_BYTES))
                    ? AW'(diff_reg - SOF_ADDR_W'(MEM_BYTES)) : AW'(diff_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
        end else begin
            stage_reg <= {stage_reg[2:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            addr_reg <= addr_in;
        end
        quot_reg <= quot_next;
        diff_reg <= diff_next;
        rem_reg  <= rem_next;
    end

    assign done = stage_reg[3];
    assign rem  = rem_reg;

endmodule

`default_nettype wire

### hdl/segmented_operand_fetch_core.sv
// Path to m_tvalid: writes, kind none and immediate go straight to the output stage;
// a register operand passes the register read; a memory operand passes register read,
// segment read and bounds check, address wrap, then reads N = 1, 2 or 4 bytes, one byte
// per cycle. A bad selector faults after the register read, a bounds fault after the
// check; a result waits in S_OUT while an earlier one stalls. One item in flight. Reset
// (aresetn low, synchronous) clears reg/segment valid bits and control, not the byte RAM.
`default_nettype none

module segmented_operand_fetch_core
    import sof_pkg::*;
#(
    parameter int MEM_BYTES    = 16384,
    parameter int NUM_SEGMENTS = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // operand_word[23:0], target_index[37:24], write_value[69:38],
    // seg_base_in[85:70], seg_size_in[101:86], zero pad
    input  wire logic [103:0] s_tdata,
    // action[1:0], operand_kind[3:2]
    input  wire logic [3:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // operand_value[31:0]
    output logic [31:0]       m_tdata,
    // segment_fault[0]
    output logic [0:0]        m_tuser
);

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int SEGW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_REG, S_SEG, S_MOD, S_BYTE, S_OUT
    } state_t;

    state_t state_reg;

    // input fields
    logic [23:0] in_word;
    logic [13:0] in_target;
    logic [31:0] in_wval;
    logic [15:0] in_base;
    logic [15:0] in_size;
    sof_action_t in_action;
    sof_kind_t   in_kind;
    logic        accept;

    assign in_word   = s_tdata[23:0];
    assign in_target = s_tdata[37:24];
    assign in_wval   = s_tdata[69:38];
    assign in_base   = s_tdata[85:70];
    assign in_size   = s_tdata[101:86];
    assign in_action = sof_action_t'(s_tuser[1:0]);
    assign in_kind   = sof_kind_t'(s_tuser[3:2]);
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;

    // item context
    logic [23:0]     word_reg;
    sof_kind_t       kind_reg;
    logic            reg_vld_reg;
    logic            seg_vld_reg;
    logic [15:0]     off_reg;
    logic [31:0]     res_val_reg;
    logic            res_fault_reg;
    logic [AW-1:0]   addr_cur_reg;
    logic [2:0]      issue_left_reg;
    logic [2:0]      recv_left_reg;
    logic            pend_reg;
    logic [31:0]     gather_reg;
    logic            m_tvalid_reg;
    logic [31:0]     m_tdata_reg;
    logic            m_tuser_reg;
    logic            out_load;

    logic [REG_COUNT-1:0]    reg_valid_reg;
    logic [NUM_SEGMENTS-1:0] seg_valid_reg;

    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    // register file RAM
    logic              rf_we;
    logic [31:0]       rf_rdata;

    assign rf_we = accept && (in_action == ACT_WREG) && (in_target < 14'(REG_COUNT));

    sof_ram #(.WIDTH(32), .DEPTH(REG_COUNT), .AW(REG_AW)) u_rf_ram (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (in_target[REG_AW-1:0]),
        .wdata (in_wval),
        .re    (accept),
        .raddr (in_word[7:4]),
        .rdata (rf_rdata)
    );

    // segment table RAM
    logic              sg_we;
    logic              sg_re;
    logic [31:0]       sg_rdata;
    logic [31:0]       r_val;
    logic              seg_ok;

    assign r_val  = reg_vld_reg ? rf_rdata : 32'd0;
    assign seg_ok = r_val[31:16] < 16'(NUM_SEGMENTS);
    assign sg_we  = accept && (in_action == ACT_WSEG) && (in_target < 14'(NUM_SEGMENTS));
    assign sg_re  = (state_reg == S_REG);

    sof_ram #(.WIDTH(32), .DEPTH(NUM_SEGMENTS), .AW(SEGW)) u_seg_ram (
        .aclk  (aclk),
        .we    (sg_we),
        .waddr (SEGW'(in_target)),
        .wdata ({in_base, in_size}),
        .re    (sg_re),
        .raddr (SEGW'(r_val[31:16])),
        .rdata (sg_rdata)
    );

    // bounds check
    logic [31:0]           seg_val;
    logic [17:0]           rel;
    logic [18:0]           rel_end;
    logic [2:0]            cells;
    logic                  bound_fault;
    logic [SOF_ADDR_W:0]   abs_addr;
    logic                  mod_start;
    logic                  mod_done;
    logic [AW-1:0]         mod_rem;

    always_comb begin
        seg_val     = seg_vld_reg ? sg_rdata : 32'd0;
        cells       = cells_of(word_reg[1:0]);
        rel         = {2'b00, off_reg} + {{2{word_reg[23]}}, word_reg[23:8]};
        rel_end     = {1'b0, rel} + 19'(cells);
        bound_fault = rel[17] || (rel_end > {3'b000, seg_val[15:0]});
        abs_addr    = (SOF_ADDR_W + 1)'(seg_val[31:16]) + rel[SOF_ADDR_W:0];
        mod_start   = (state_reg == S_SEG) && !bound_fault;
    end

    sof_addr_mod #(.MEM_BYTES(MEM_BYTES), .AW(AW)) u_addr_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .addr_in (abs_addr[SOF_ADDR_W-1:0]),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    // byte RAM
    logic              mem_we;
    logic              mem_re;
    logic [7:0]        mem_rdata;
    logic [31:0]       gather_next;

    assign mem_we      = accept && (in_action == ACT_WMEM)
                         && ((SOF_ADDR_W)'(in_target) < (SOF_ADDR_W)'(MEM_BYTES));
    assign mem_re      = (state_reg == S_BYTE) && (issue_left_reg != 3'd0);
    assign gather_next = {gather_reg[23:0], mem_rdata};

    sof_ram #(.WIDTH(8), .DEPTH(MEM_BYTES), .AW(AW)) u_byte_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (AW'(in_target)),
        .wdata (in_wval[7:0]),
        .re    (mem_re),
        .raddr (addr_cur_reg),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_tvalid_reg  <= 1'b0;
            reg_valid_reg <= '0;
            seg_valid_reg <= '0;
            pend_reg      <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (rf_we) begin
                reg_valid_reg[in_target[REG_AW-1:0]] <= 1'b1;
            end
            if (sg_we) begin
                seg_valid_reg[SEGW'(in_target)] <= 1'b1;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        word_reg      <= in_word;
                        kind_reg      <= in_kind;
                        reg_vld_reg   <= reg_valid_reg[in_word[7:4]];
                        res_val_reg   <= (in_action == ACT_FETCH && in_kind == KIND_IMM)
                                         ? {8'd0, in_word} : 32'd0;
                        res_fault_reg <= 1'b0;
                        if (in_action != ACT_FETCH) begin
                            state_reg <= S_OUT;
                        end else if (in_kind == KIND_IMM) begin
                            state_reg <= S_OUT;
                        end else if (in_kind == KIND_NONE) begin
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_REG;
                        end
                    end
                end
                S_REG: begin
                    off_reg     <= r_val[15:0];
                    seg_vld_reg <= seg_valid_reg[SEGW'(r_val[31:16])];
                    if (kind_reg == KIND_REG) begin
                        res_val_reg <= reg_operand(r_val, word_reg[3:2]);
                        state_reg   <= S_OUT;
                    end else if (!seg_ok) begin
                        res_fault_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end else begin
                        state_reg <= S_SEG;
                    end
                end
                S_SEG: begin
                    if (bound_fault) begin
                        res_fault_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end else begin
                        state_reg <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        addr_cur_reg   <= mod_rem;
                        issue_left_reg <= cells;
                        recv_left_reg  <= cells;
                        pend_reg       <= 1'b0;
                        gather_reg     <= 32'd0;
                        state_reg      <= S_BYTE;
                    end
                end
                S_BYTE: begin
                    pend_reg <= mem_re;
                    if (mem_re) begin
                        issue_left_reg <= issue_left_reg - 3'd1;
                        addr_cur_reg   <= (addr_cur_reg == AW'(MEM_BYTES - 1)) ? '0
                                          : addr_cur_reg + 1'b1;
                    end
                    if (pend_reg) begin
                        gather_reg    <= gather_next;
                        recv_left_reg <= recv_left_reg - 3'd1;
                        if (recv_left_reg == 3'd1) begin
                            res_val_reg <= gather_next;
                            state_reg   <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        m_tdata_reg <= res_val_reg;
                        m_tuser_reg <= res_fault_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

### hdl/sof_core_checker.sv
// Port-level checks for segmented_operand_fetch_core, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module sof_core_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [31:0]  m_tdata,
    input wire logic [0:0]   m_tuser
);

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a faulting fetch carries a zero value
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("fault with nonzero operand value");

    // one item in flight: no input transfer right after another
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind segmented_operand_fetch_core sof_core_checker u_sof_core_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### verif/sof_fetch_checker.sv
// Result checker for segmented_operand_fetch_core: watches both stream channels, tracks the
// registers, segment descriptors and byte RAM, and compares every result transfer.
// Depends on sof_pkg for the action, operand kind and size modifier codes.
`timescale 1ns / 1ps

module sof_fetch_checker
    import sof_pkg::*;
#(
    parameter int MEM_BYTES    = 16384,
    parameter int NUM_SEGMENTS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic [3:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    input  logic [0:0]   m_tuser,
    output int           error_count,
    output int           pending_count,
    output int           result_count,
    output int           fault_count
);

    typedef struct packed {
        logic [31:0] value;
        logic        fault;
    } operand_result_t;

    logic [31:0] reg_file [REG_COUNT];
    logic [15:0] seg_base [NUM_SEGMENTS];
    logic [15:0] seg_len  [NUM_SEGMENTS];
    logic [7:0]  ram      [MEM_BYTES];

    operand_result_t expected_operands[$];
    int errors  = 0;
    int results = 0;
    int faults  = 0;

    function automatic operand_result_t resolve_operand(input sof_kind_t kind,
                                                        input logic [23:0] word);
        operand_result_t res;
        logic [31:0] r;
        logic [15:0] sel;
        shortint disp;
        int lo, hi, addr, nbytes, i;
        res = '0;
        r = reg_file[word[7:4]];
        case (kind)
            KIND_REG: begin
                case (sof_rmod_t'(word[3:2]))
                    RMOD_FULL:  res.value = r;
                    RMOD_LOW8:  res.value = {{24{r[7]}}, r[7:0]};
                    RMOD_HIGH8: res.value = {{24{r[15]}}, r[15:8]};
                    default:    res.value = {{16{r[15]}}, r[15:0]};
                endcase
            end
            KIND_IMM: res.value = {8'h00, word};
            KIND_MEM: begin
                sel = r[31:16];
                nbytes = (word[1:0] == SMOD_BYTE) ? 1 : (word[1:0] == SMOD_HALF) ? 2 : 4;
                if (sel >= NUM_SEGMENTS) begin
                    res.fault = 1'b1;
                end else begin
                    disp = shortint'(word[23:8]);
                    lo = int'(seg_base[sel]);
                    hi = lo + int'(seg_len[sel]);
                    addr = lo + int'(r[15:0]) + disp;
                    if (addr < lo || addr + nbytes > hi) begin
                        res.fault = 1'b1;
                    end else begin
                        for (i = 0; i < nbytes; i++)
                            res.value = {res.value[23:0], ram[(addr + i) % MEM_BYTES]};
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        operand_result_t res;
        operand_result_t want;
        logic [13:0] tgt;
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) reg_file[i] = '0;
            for (int i = 0; i < NUM_SEGMENTS; i++) begin
                seg_base[i] = '0;
                seg_len[i]  = '0;
            end
            expected_operands.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                res = '0;
                tgt = s_tdata[37:24];
                case (sof_action_t'(s_tuser[1:0]))
                    ACT_FETCH: res = resolve_operand(sof_kind_t'(s_tuser[3:2]), s_tdata[23:0]);
                    ACT_WREG:  if (tgt < REG_COUNT) reg_file[tgt[REG_AW-1:0]] = s_tdata[69:38];
                    ACT_WSEG: begin
                        if (tgt < NUM_SEGMENTS) begin
                            seg_base[tgt] = s_tdata[85:70];
                            seg_len[tgt]  = s_tdata[101:86];
                        end
                    end
                    default:   if (tgt < MEM_BYTES) ram[tgt] = s_tdata[45:38];
                endcase
                expected_operands.push_back(res);
            end
            if (m_tvalid && m_tready) begin
                results++;
                if (m_tuser[0]) faults++;
                if (expected_operands.size() == 0) begin
                    $error("result transfer with nothing outstanding: operand_value %h, segment_fault %b",
                           m_tdata, m_tuser[0]);
                    errors++;
                end else begin
                    want = expected_operands.pop_front();
                    if (m_tdata !== want.value) begin
                        $error("operand_value: expected %h, got %h", want.value, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== want.fault) begin
                        $error("segment_fault: expected %b, got %b", want.fault, m_tuser[0]);
                        errors++;
                    end
                end
            end
        end
        error_count   <= errors;
        pending_count <= expected_operands.size();
        result_count  <= results;
        fault_count   <= faults;
    end

endmodule

### verif/tb_segmented_operand_fetch_core.sv
// Top testbench for segmented_operand_fetch_core: drives directed and random stream traffic
// with bursty input and stalling output, and gives the verdict from sof_fetch_checker.
// Depends on sof_pkg, the block RTL and verif/sof_fetch_checker.sv.
`timescale 1ns / 1ps

module tb_segmented_operand_fetch_core;
    import sof_pkg::*;

    localparam int MEM_BYTES    = 16384;
    localparam int NUM_SEGMENTS = 8;
    localparam int ITEM_TARGET  = 850;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 24;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata  = '0;
    logic [3:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [0:0]   m_tuser;

    int error_count, pending_count, result_count, fault_count;

    // stimulus-side copy of the state, so no fetch ever reads a RAM byte never written
    logic [31:0] shadow_regs [REG_COUNT];
    logic [15:0] shadow_base [NUM_SEGMENTS];
    logic [15:0] shadow_len  [NUM_SEGMENTS];
    bit          ram_written [MEM_BYTES];

    int items_sent  = 0;
    int mem_fetches = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int stall_mode  = 0;
    int mode_left   = 0;
    int stall_phase = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    segmented_operand_fetch_core #(
        .MEM_BYTES   (MEM_BYTES),
        .NUM_SEGMENTS(NUM_SEGMENTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    sof_fetch_checker #(
        .MEM_BYTES   (MEM_BYTES),
        .NUM_SEGMENTS(NUM_SEGMENTS)
    ) fetch_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .error_count  (error_count),
        .pending_count(pending_count),
        .result_count (result_count),
        .fault_count  (fault_count)
    );

    function automatic int wrap_addr(input int a);
        return ((a % MEM_BYTES) + MEM_BYTES) % MEM_BYTES;
    endfunction

    function automatic logic [23:0] operand_word(input logic [15:0] disp, input logic [3:0] rsel,
                                                 input logic [1:0] rmod, input logic [1:0] smod);
        return {disp, rsel, rmod, smod};
    endfunction

    // true when the fetch faults or every byte it reads has been written
    function automatic bit mem_read_defined(input logic [23:0] word);
        logic [31:0] r;
        shortint disp;
        int lo, addr, nbytes, i;
        r = shadow_regs[word[7:4]];
        if (r[31:16] >= NUM_SEGMENTS) return 1'b1;
        disp = shortint'(word[23:8]);
        lo = int'(shadow_base[r[31:16]]);
        addr = lo + int'(r[15:0]) + disp;
        nbytes = (word[1:0] == SMOD_BYTE) ? 1 : (word[1:0] == SMOD_HALF) ? 2 : 4;
        if (addr < lo || addr + nbytes > lo + int'(shadow_len[r[31:16]])) return 1'b1;
        for (i = 0; i < nbytes; i++)
            if (!ram_written[wrap_addr(addr + i)]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic send(input sof_action_t act, input sof_kind_t kind, input logic [23:0] word,
                        input logic [13:0] tgt, input logic [31:0] wval,
                        input logic [15:0] sb, input logic [15:0] ss);
        sof_kind_t k;
        int gap;
        k = kind;
        if (act == ACT_FETCH && kind == KIND_MEM && !mem_read_defined(word)) k = KIND_IMM;
        if (act == ACT_FETCH && k == KIND_MEM) mem_fetches++;
        s_tvalid <= 1'b1;
        s_tuser  <= {k, act};
        s_tdata  <= {2'b00, ss, sb, wval, tgt, word};
        do @(posedge aclk); while (!s_tready);
        case (act)
            ACT_WREG: if (tgt < REG_COUNT) shadow_regs[tgt[REG_AW-1:0]] = wval;
            ACT_WSEG: begin
                if (tgt < NUM_SEGMENTS) begin
                    shadow_base[tgt] = sb;
                    shadow_len[tgt]  = ss;
                end
            end
            ACT_WMEM: if (tgt < MEM_BYTES) ram_written[tgt] = 1'b1;
            default: ;
        endcase
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            if ($urandom_range(0, 9) < 4) gap = 0;
            else if ($urandom_range(0, 15) == 0) gap = 20;
            else gap = $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(32, 200);
        end
        mode_left--;
        stall_phase++;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (stall_phase % 6 == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_segmented_operand_fetch_core failed");
            $finish;
        end
    end

    initial begin
        int seg, rsel, size, offset, origin;
        logic [15:0] base;
        byte unsigned pattern [4];
        pattern = '{8'hDE, 8'hAD, 8'hBE, 8'hEF};
        for (int i = 0; i < REG_COUNT; i++) shadow_regs[i] = '0;
        for (int i = 0; i < NUM_SEGMENTS; i++) begin
            shadow_base[i] = '0;
            shadow_len[i]  = '0;
        end
        burst_left = $urandom_range(1, 24);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: operand forms, sign extension, ignored writes, faults, RAM wrap
        send(ACT_FETCH, KIND_NONE, 24'($urandom), 14'($urandom), $urandom, 16'($urandom), 16'($urandom));
        send(ACT_FETCH, KIND_REG, operand_word(16'h0, 4'd0, RMOD_FULL, 2'd0), '0, '0, '0, '0);
        send(ACT_WREG, KIND_NONE, '0, 14'd1, 32'h7FFF_FFFF, '0, '0);
        send(ACT_WREG, KIND_MEM, '1, 14'd2, 32'h8000_8081, '1, '1);
        send(ACT_FETCH, KIND_REG, operand_word(16'h0, 4'd1, RMOD_FULL, 2'd0), '0, '0, '0, '0);
        send(ACT_FETCH, KIND_REG, operand_word(16'h0, 4'd2, RMOD_LOW8, 2'd0), '0, '0, '0, '0);
        send(ACT_FETCH, KIND_REG, operand_word(16'h0, 4'd2, RMOD_HIGH8, 2'd0), '0, '0, '0, '0);
        send(ACT_FETCH, KIND_REG, operand_word(16'h0, 4'd2, RMOD_LOW16, 2'd0), '0, '0, '0, '0);
        send(ACT_FETCH, KIND_IMM, 24'hFF_FFFF, '0, '0, '0, '0);
        send(ACT_WREG, KIND_NONE, '0, 14'h3FFF, $urandom, '0, '0);
        send(ACT_WSEG, KIND_NONE, '0, 14'(NUM_SEGMENTS), '0, 16'hFFFF, 16'hFFFF);
        send(ACT_WSEG, KIND_NONE, '0, 14'd0, '0, 16'h0100, 16'h0010);
        send(ACT_WREG, KIND_NONE, '0, 14'd5, 32'h0000_0004, '0, '0);
        for (int i = 0; i < 4; i++)
            send(ACT_WMEM, KIND_NONE, '0, 14'h104 + 14'(i), {24'hFF_FFFF, pattern[i]}, '0, '0);
        send(ACT_FETCH, KIND_MEM, operand_word(16'h0000, 4'd5, RMOD_FULL, 2'd0), '0, '0, '0, '0);
        send(ACT_FETCH, KIND_MEM, operand_word(16'h0002, 4'd5, RMOD_FULL, SMOD_HALF), '0, '0, '0, '0);
        send(ACT_FETCH, KIND_MEM, operand_word(16'hFFF8, 4'd5, RMOD_FULL, SMOD_BYTE), '0, '0, '0, '0);
        send(ACT_FETCH, KIND_MEM, operand_word(16'h000B, 4'd5, RMOD_FULL, 2'd1), '0, '0, '0, '0);
        send(ACT_WREG, KIND_NONE, '0, 14'd6, {16'(NUM_SEGMENTS), 16'h0000}, '0, '0);
        send(ACT_FETCH, KIND_MEM, operand_word(16'h0000, 4'd6, RMOD_FULL, 2'd0), '0, '0, '0, '0);
        send(ACT_WSEG, KIND_NONE, '0, 14'(NUM_SEGMENTS - 1), '0, 16'hFFF0, 16'hFFFF);
        send(ACT_WREG, KIND_NONE, '0, 14'd7, {16'(NUM_SEGMENTS - 1), 16'h0000}, '0, '0);
        send(ACT_WMEM, KIND_NONE, '0, 14'(wrap_addr(32'hFFF0)), 32'h0000_00A5, '0, '0);
        send(ACT_FETCH, KIND_MEM, operand_word(16'h0000, 4'd7, RMOD_FULL, SMOD_BYTE), '0, '0, '0, '0);

        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    // segment, pointer register, bytes around the target, then reads
                    seg  = $urandom_range(0, NUM_SEGMENTS - 1);
                    rsel = $urandom_range(0, REG_COUNT - 1);
                    case ($urandom_range(0, 3))
                        0:       base = 16'($urandom);
                        1:       base = 16'($urandom_range(0, 255));
                        2:       base = 16'($urandom_range(16'hFF00, 16'hFFFF));
                        default: base = 16'($urandom_range(0, MEM_BYTES - 1));
                    endcase
                    size = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 48);
                    offset = $urandom_range(0, size);
                    send(ACT_WSEG, sof_kind_t'($urandom_range(0, 3)), 24'($urandom), 14'(seg),
                         $urandom, base, 16'(size));
                    send(ACT_WREG, sof_kind_t'($urandom_range(0, 3)), 24'($urandom), 14'(rsel),
                         {16'(seg), 16'(offset)}, 16'($urandom), 16'($urandom));
                    origin = int'(base) + offset;
                    for (int i = -1; i < 8; i++)
                        send(ACT_WMEM, sof_kind_t'($urandom_range(0, 3)), 24'($urandom),
                             14'(wrap_addr(origin + i)), $urandom, 16'($urandom), 16'($urandom));
                    repeat ($urandom_range(2, 6))
                        send(ACT_FETCH, KIND_MEM,
                             operand_word(16'($urandom_range(0, 6) - 1), 4'(rsel),
                                          2'($urandom), 2'($urandom)),
                             14'($urandom), $urandom, 16'($urandom), 16'($urandom));
                end
                6: begin
                    repeat ($urandom_range(1, 3))
                        send(ACT_WREG, KIND_NONE, 24'($urandom),
                             ($urandom_range(0, 7) == 0) ? 14'($urandom)
                                                         : 14'($urandom_range(0, REG_COUNT - 1)),
                             $urandom, 16'($urandom), 16'($urandom));
                    repeat ($urandom_range(1, 4))
                        send(ACT_FETCH, KIND_REG, 24'($urandom), 14'($urandom), $urandom,
                             16'($urandom), 16'($urandom));
                end
                7: send(ACT_FETCH, $urandom_range(0, 1) ? KIND_IMM : KIND_NONE, 24'($urandom),
                        14'($urandom), $urandom, 16'($urandom), 16'($urandom));
                8: send(sof_action_t'($urandom_range(0, 3)), sof_kind_t'($urandom_range(0, 3)),
                        24'($urandom), 14'($urandom), $urandom, 16'($urandom), 16'($urandom));
                default: begin
                    // bad segment selector or wild displacement
                    if ($urandom_range(0, 1)) begin
                        rsel = $urandom_range(0, REG_COUNT - 1);
                        send(ACT_WREG, KIND_NONE, 24'($urandom), 14'(rsel),
                             {16'($urandom_range(NUM_SEGMENTS, 65535)), 16'($urandom)},
                             16'($urandom), 16'($urandom));
                        send(ACT_FETCH, KIND_MEM,
                             operand_word(16'($urandom), 4'(rsel), 2'($urandom), 2'($urandom)),
                             14'($urandom), $urandom, 16'($urandom), 16'($urandom));
                    end else begin
                        send(ACT_FETCH, KIND_MEM, 24'($urandom), 14'($urandom), $urandom,
                             16'($urandom), 16'($urandom));
                    end
                end
            endcase
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d input transfers, %0d of them memory operand fetches.",
                 items_sent, mem_fetches);
        $display("Checked %0d result transfers, %0d of them with a segment fault.",
                 result_count, fault_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("tb_segmented_operand_fetch_core passed");
        end else begin
            $display("tb_segmented_operand_fetch_core failed");
        end
        $finish;
    end

endmodule
